/* src/tmmt_pkg.sv */
`timescale 1ns / 1ps

package tmmt_pkg;

	// Field and register widths.
	localparam int DATA_W     = 16;
	localparam int MOVE_W     = 8;
	localparam int MODE_W     = 2;
	localparam int GAIN_W     = 10;
	localparam int THR_W      = 12;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;
	localparam int KEY_W      = 3;

	// Longest key tap burst for one report.
	localparam int MAX_TAPS   = 15;
	localparam int TAP_CNT_W  = $clog2(MAX_TAPS + 1);
	localparam int NT_W       = $clog2(MAX_TAPS * (2 ** THR_W));
	localparam int SUM_W      = DATA_W + 1;
	localparam int CMP_W      = (NT_W > SUM_W) ? NT_W : SUM_W;

	// Saturation limits.
	localparam int SAT_LIM    = 32767;
	localparam int CLAMP_MAX  = 127;
	localparam int MAG_W      = $clog2(CLAMP_MAX + 1);

	// Cursor scaling: gain is in percent. A product at or above CUR_SAT_PROD clamps,
	// below it the divide by 100 is a multiply by a rounded-up reciprocal.
	localparam int PERCENT      = 100;
	localparam int CUR_SAT_PROD = (CLAMP_MAX + 1) * PERCENT;
	localparam int DIV100_SHIFT = 19;
	localparam int DIV100_RECIP = (2 ** DIV100_SHIFT) / PERCENT + 1;
	localparam int MUL_A_W      = DATA_W;
	localparam int MUL_B_W      = 13;
	localparam int MUL_P_W      = MUL_A_W + MUL_B_W;
	localparam int CUR_LOW_W    = $clog2(CUR_SAT_PROD);

	// Wheel step divider: the quotient saturates at CLAMP_MAX, so MAG_W bits suffice.
	localparam int DIV_W      = THR_W + MAG_W;
	localparam int DIV_CNT_W  = $clog2(MAG_W);

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_MODE          = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTEGRATE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN          = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_INT      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ARROW_THR     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ARROW_THR_INT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_WHEEL_THR     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_WHEEL_THR_INT = 3'd7;

	// Register reset values.
	localparam logic [MODE_W-1:0] RST_MODE          = 2'd0;
	localparam logic [GAIN_W-1:0] RST_GAIN          = 10'd250;
	localparam logic [GAIN_W-1:0] RST_GAIN_INT      = 10'd20;
	localparam logic [7:0]        RST_ARROW_THR     = 8'd24;
	localparam logic [THR_W-1:0]  RST_ARROW_THR_INT = 12'd340;
	localparam logic [7:0]        RST_WHEEL_THR     = 8'd1;
	localparam logic [THR_W-1:0]  RST_WHEEL_THR_INT = 12'd150;

	// Operating modes.
	localparam logic [MODE_W-1:0] MODE_CURSOR = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ARROW  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SCROLL = 2'd2;
	localparam logic [MODE_W-1:0] MODE_MEDIA  = 2'd3;

	// Key codes.
	localparam logic [KEY_W-1:0] KEY_RIGHT       = 3'd0;
	localparam logic [KEY_W-1:0] KEY_LEFT        = 3'd1;
	localparam logic [KEY_W-1:0] KEY_UP          = 3'd2;
	localparam logic [KEY_W-1:0] KEY_DOWN        = 3'd3;
	localparam logic [KEY_W-1:0] KEY_BRIGHT_UP   = 3'd4;
	localparam logic [KEY_W-1:0] KEY_BRIGHT_DOWN = 3'd5;
	localparam logic [KEY_W-1:0] KEY_VOL_UP      = 3'd6;
	localparam logic [KEY_W-1:0] KEY_VOL_DOWN    = 3'd7;

	// Beat kinds.
	localparam logic KIND_TAP   = 1'b0;
	localparam logic KIND_MOUSE = 1'b1;

	// Signed add saturated to plus or minus SAT_LIM.
	function automatic logic signed [DATA_W-1:0] sat_add(input logic signed [DATA_W-1:0] a,
		input logic signed [DATA_W-1:0] b);
		logic signed [DATA_W:0] s;
		s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
		if (s > (DATA_W+1)'(SAT_LIM)) begin
			return DATA_W'(SAT_LIM);
		end else if (s < -(DATA_W+1)'(SAT_LIM)) begin
			return -DATA_W'(SAT_LIM);
		end
		return s[DATA_W-1:0];
	endfunction

	// Magnitude as an unsigned value; the most negative input maps to its true size.
	function automatic logic [DATA_W-1:0] mag(input logic signed [DATA_W-1:0] v);
		return v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
	endfunction

	// Attach a sign to a clamped magnitude.
	function automatic logic signed [MOVE_W-1:0] signed_mag(input logic neg,
		input logic [MAG_W-1:0] m);
		logic signed [MOVE_W-1:0] v;
		v = $signed({1'b0, m});
		return neg ? -v : v;
	endfunction

endpackage

/* src/trackball_motion_mode_translator.sv */
// The block takes one input beat at a time: in_ready is high only in the idle state, so
// a new beat waits until the closing report of the last one is loaded. The work per beat
// is the shared multiplier sequence, the 7-step wheel divider or the tap loop of up to
// 15 taps, and an output beat held by the sink stalls the tap loop and the closing report.
// Reset (arst_n low, asynchronous): registers take their documented defaults, held
// values and accumulators clear, and the output register empties.
`timescale 1ns / 1ps

module trackball_motion_mode_translator (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [tmmt_pkg::DATA_W-1:0]   delta_x,
	input  logic signed [tmmt_pkg::DATA_W-1:0]   delta_y,
	input  logic                                 fresh_sample,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 item_kind,
	output logic [tmmt_pkg::KEY_W-1:0]           key_code,
	output logic signed [tmmt_pkg::MOVE_W-1:0]   move_x,
	output logic signed [tmmt_pkg::MOVE_W-1:0]   move_y,
	output logic signed [tmmt_pkg::MOVE_W-1:0]   wheel_h,
	output logic signed [tmmt_pkg::MOVE_W-1:0]   wheel_v,
	output logic                                 last,
	input  logic                                 cfg_we,
	input  logic [tmmt_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tmmt_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

	// The sequencer walks each input beat through a handful of states. Cursor mode runs
	// the shared multiplier four times (gain, then reciprocal of 100, for each axis).
	// The other modes add the held values into the accumulators, compare the summed
	// magnitude against the threshold, and if it is reached either saturate or run the
	// restoring divider for a wheel step, or loop once per key tap. Every beat ends in the
	// REPORT state, which loads the closing mouse report.
	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_HOLD   = 9'b000000010,
		ST_ACC    = 9'b000000100,
		ST_SUM    = 9'b000001000,
		ST_CMUL   = 9'b000010000,
		ST_CSCL   = 9'b000100000,
		ST_DIV    = 9'b001000000,
		ST_TAP    = 9'b010000000,
		ST_REPORT = 9'b100000000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [tmmt_pkg::MODE_W-1:0] mode_q;
	logic                        integ_q;
	logic [tmmt_pkg::GAIN_W-1:0] gain_q;
	logic [tmmt_pkg::GAIN_W-1:0] gain_int_q;
	logic [7:0]                  arrow_thr_q;
	logic [tmmt_pkg::THR_W-1:0]  arrow_thr_int_q;
	logic [7:0]                  wheel_thr_q;
	logic [tmmt_pkg::THR_W-1:0]  wheel_thr_int_q;

	// Architectural state.
	logic signed [tmmt_pkg::DATA_W-1:0] held_x_q, held_y_q;
	logic signed [tmmt_pkg::DATA_W-1:0] accum_x_q, accum_y_q;

	// Captured input beat.
	logic signed [tmmt_pkg::DATA_W-1:0] dx_q, dy_q;
	logic                               fresh_q;

	// Working registers.
	logic                                axis_q;
	logic [tmmt_pkg::MUL_P_W-1:0]        prod_q;
	logic                                dom_x_q;
	logic                                neg_q;
	logic [tmmt_pkg::KEY_W-1:0]          code_q;
	logic [tmmt_pkg::TAP_CNT_W-1:0]      n_q;
	logic [tmmt_pkg::NT_W-1:0]           nt_q;
	logic [tmmt_pkg::SUM_W-1:0]          rem_q;
	logic [tmmt_pkg::MAG_W-1:0]          quo_q;
	logic [tmmt_pkg::DIV_CNT_W-1:0]      div_cnt_q;
	logic signed [tmmt_pkg::MOVE_W-1:0]  mx_q, my_q, wh_q, wv_q;

	// Output register.
	logic                                out_valid_q;
	logic                                out_kind_q;
	logic [tmmt_pkg::KEY_W-1:0]          out_code_q;
	logic signed [tmmt_pkg::MOVE_W-1:0]  out_mx_q, out_my_q, out_wh_q, out_wv_q;
	logic                                out_last_q;

	logic out_free;
	logic in_acc;
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;

	// Selected gain and threshold. A zero threshold behaves as one.
	logic [tmmt_pkg::GAIN_W-1:0] gain_c;
	logic [tmmt_pkg::THR_W-1:0]  thr_raw;
	logic [tmmt_pkg::THR_W-1:0]  thr_c;

	always_comb begin
		gain_c = integ_q ? gain_int_q : gain_q;
		case (mode_q)
			tmmt_pkg::MODE_SCROLL: begin
				thr_raw = integ_q ? wheel_thr_int_q : tmmt_pkg::THR_W'(wheel_thr_q);
			end
			tmmt_pkg::MODE_ARROW: begin
				thr_raw = integ_q ? arrow_thr_int_q : tmmt_pkg::THR_W'(arrow_thr_q);
			end
			default: begin
				thr_raw = tmmt_pkg::THR_W'(arrow_thr_q);
			end
		endcase
		thr_c = (thr_raw == '0) ? tmmt_pkg::THR_W'(1) : thr_raw;
	end

	// Summed magnitude of the accumulators, shared by the threshold test and the tap loop.
	logic [tmmt_pkg::DATA_W-1:0] abs_ax, abs_ay;
	logic [tmmt_pkg::SUM_W-1:0]  sum_c;
	assign abs_ax = tmmt_pkg::mag(accum_x_q);
	assign abs_ay = tmmt_pkg::mag(accum_y_q);
	assign sum_c  = {1'b0, abs_ax} + {1'b0, abs_ay};

	// Shared unsigned multiplier.
	logic [tmmt_pkg::MUL_A_W-1:0] mul_a;
	logic [tmmt_pkg::MUL_B_W-1:0] mul_b;
	logic [tmmt_pkg::MUL_P_W-1:0] mul_p;

	always_comb begin
		if (state_q == ST_CSCL) begin
			mul_a = tmmt_pkg::MUL_A_W'(prod_q[tmmt_pkg::CUR_LOW_W-1:0]);
			mul_b = tmmt_pkg::MUL_B_W'(tmmt_pkg::DIV100_RECIP);
		end else begin
			mul_a = axis_q ? tmmt_pkg::mag(held_y_q) : tmmt_pkg::mag(held_x_q);
			mul_b = tmmt_pkg::MUL_B_W'(gain_c);
		end
		mul_p = tmmt_pkg::MUL_P_W'(mul_a) * tmmt_pkg::MUL_P_W'(mul_b);
	end

	// Clamped cursor magnitude. The y axis is negated on the way out.
	logic [tmmt_pkg::MAG_W-1:0]         cur_mag;
	logic                               cur_neg;
	logic signed [tmmt_pkg::MOVE_W-1:0] cur_val;

	always_comb begin
		if (prod_q >= tmmt_pkg::MUL_P_W'(tmmt_pkg::CUR_SAT_PROD)) begin
			cur_mag = tmmt_pkg::MAG_W'(tmmt_pkg::CLAMP_MAX);
		end else begin
			cur_mag = mul_p[tmmt_pkg::DIV100_SHIFT +: tmmt_pkg::MAG_W];
		end
		cur_neg = axis_q ? !held_y_q[tmmt_pkg::DATA_W-1] : held_x_q[tmmt_pkg::DATA_W-1];
		cur_val = tmmt_pkg::signed_mag(cur_neg, cur_mag);
	end

	// One restoring divide step: subtract the threshold shifted by the bit position.
	logic [tmmt_pkg::DIV_W-1:0] div_d;
	logic                       div_ge;
	logic [tmmt_pkg::SUM_W-1:0] rem_n;
	logic [tmmt_pkg::MAG_W-1:0] quo_n;
	logic                       wheel_sat;

	always_comb begin
		div_d     = tmmt_pkg::DIV_W'(thr_c) << div_cnt_q;
		div_ge    = tmmt_pkg::DIV_W'(rem_q) >= div_d;
		rem_n     = div_ge ? (rem_q - tmmt_pkg::SUM_W'(div_d)) : rem_q;
		quo_n     = quo_q | (tmmt_pkg::MAG_W'(div_ge) << div_cnt_q);
		wheel_sat = tmmt_pkg::DIV_W'(sum_c) >= (tmmt_pkg::DIV_W'(thr_c) << tmmt_pkg::MAG_W);
	end

	// Key tap loop: tap n is due while n times the threshold fits in the current sum.
	logic tap_go;
	assign tap_go = (n_q < tmmt_pkg::TAP_CNT_W'(tmmt_pkg::MAX_TAPS))
		&& (tmmt_pkg::CMP_W'(nt_q) <= tmmt_pkg::CMP_W'(sum_c));

	// The output register takes a key tap or the closing report whenever it is free.
	logic out_load;
	assign out_load = out_free && ((state_q == ST_TAP && tap_go) || state_q == ST_REPORT);

	// The dominant accumulator moves toward zero by the threshold and stops at zero.
	logic signed [tmmt_pkg::DATA_W:0]   dom_v, pull_w, thr_s;
	logic signed [tmmt_pkg::DATA_W-1:0] pull_v;

	always_comb begin
		dom_v = dom_x_q ? {accum_x_q[tmmt_pkg::DATA_W-1], accum_x_q}
			: {accum_y_q[tmmt_pkg::DATA_W-1], accum_y_q};
		thr_s = $signed((tmmt_pkg::DATA_W+1)'(thr_c));
		if (dom_v > 0) begin
			pull_w = dom_v - thr_s;
			pull_v = (pull_w > 0) ? pull_w[tmmt_pkg::DATA_W-1:0] : '0;
		end else begin
			pull_w = dom_v + thr_s;
			pull_v = (pull_w < 0) ? pull_w[tmmt_pkg::DATA_W-1:0] : '0;
		end
	end

	// Key code of the burst, fixed from the accumulators when the burst starts.
	logic                       dom_x_c;
	logic [tmmt_pkg::KEY_W-1:0] code_c;

	always_comb begin
		dom_x_c = abs_ax > abs_ay;
		if (mode_q == tmmt_pkg::MODE_MEDIA) begin
			if (dom_x_c) begin
				code_c = (accum_x_q > 0) ? tmmt_pkg::KEY_BRIGHT_UP : tmmt_pkg::KEY_BRIGHT_DOWN;
			end else begin
				code_c = (accum_y_q > 0) ? tmmt_pkg::KEY_VOL_UP : tmmt_pkg::KEY_VOL_DOWN;
			end
		end else begin
			if (dom_x_c) begin
				code_c = (accum_x_q > 0) ? tmmt_pkg::KEY_RIGHT : tmmt_pkg::KEY_LEFT;
			end else begin
				code_c = (accum_y_q > 0) ? tmmt_pkg::KEY_UP : tmmt_pkg::KEY_DOWN;
			end
		end
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q          <= tmmt_pkg::RST_MODE;
			integ_q         <= 1'b0;
			gain_q          <= tmmt_pkg::RST_GAIN;
			gain_int_q      <= tmmt_pkg::RST_GAIN_INT;
			arrow_thr_q     <= tmmt_pkg::RST_ARROW_THR;
			arrow_thr_int_q <= tmmt_pkg::RST_ARROW_THR_INT;
			wheel_thr_q     <= tmmt_pkg::RST_WHEEL_THR;
			wheel_thr_int_q <= tmmt_pkg::RST_WHEEL_THR_INT;
		end else if (cfg_we) begin
			case (cfg_index)
				tmmt_pkg::REG_MODE:          mode_q          <= cfg_wdata[tmmt_pkg::MODE_W-1:0];
				tmmt_pkg::REG_INTEGRATE:     integ_q         <= cfg_wdata[0];
				tmmt_pkg::REG_GAIN:          gain_q          <= cfg_wdata[tmmt_pkg::GAIN_W-1:0];
				tmmt_pkg::REG_GAIN_INT:      gain_int_q      <= cfg_wdata[tmmt_pkg::GAIN_W-1:0];
				tmmt_pkg::REG_ARROW_THR:     arrow_thr_q     <= cfg_wdata[7:0];
				tmmt_pkg::REG_ARROW_THR_INT: arrow_thr_int_q <= cfg_wdata[tmmt_pkg::THR_W-1:0];
				tmmt_pkg::REG_WHEEL_THR:     wheel_thr_q     <= cfg_wdata[7:0];
				tmmt_pkg::REG_WHEEL_THR_INT: wheel_thr_int_q <= cfg_wdata[tmmt_pkg::THR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			held_x_q    <= '0;
			held_y_q    <= '0;
			accum_x_q   <= '0;
			accum_y_q   <= '0;
			out_valid_q <= 1'b0;
			axis_q      <= 1'b0;
			n_q         <= '0;
			nt_q        <= '0;
			div_cnt_q   <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (fresh_q) begin
						if (integ_q) begin
							held_x_q <= tmmt_pkg::sat_add(held_x_q, dx_q);
							held_y_q <= tmmt_pkg::sat_add(held_y_q, dy_q);
						end else begin
							held_x_q <= dx_q;
							held_y_q <= dy_q;
						end
					end
					axis_q  <= 1'b0;
					state_q <= (mode_q == tmmt_pkg::MODE_CURSOR) ? ST_CMUL : ST_ACC;
				end
				ST_CMUL: begin
					state_q <= ST_CSCL;
				end
				ST_CSCL: begin
					axis_q  <= 1'b1;
					state_q <= axis_q ? ST_REPORT : ST_CMUL;
				end
				ST_ACC: begin
					accum_x_q <= tmmt_pkg::sat_add(accum_x_q, held_x_q);
					accum_y_q <= tmmt_pkg::sat_add(accum_y_q, held_y_q);
					state_q   <= ST_SUM;
				end
				ST_SUM: begin
					n_q       <= '0;
					nt_q      <= '0;
					div_cnt_q <= tmmt_pkg::DIV_CNT_W'(tmmt_pkg::MAG_W - 1);
					if (sum_c < tmmt_pkg::SUM_W'(thr_c)) begin
						state_q <= ST_REPORT;
					end else if (mode_q == tmmt_pkg::MODE_SCROLL) begin
						if (wheel_sat) begin
							accum_x_q <= '0;
							accum_y_q <= '0;
							state_q   <= ST_REPORT;
						end else begin
							state_q <= ST_DIV;
						end
					end else begin
						state_q <= ST_TAP;
					end
				end
				ST_DIV: begin
					if (div_cnt_q == '0) begin
						accum_x_q <= '0;
						accum_y_q <= '0;
						state_q   <= ST_REPORT;
					end else begin
						div_cnt_q <= div_cnt_q - 1'b1;
					end
				end
				ST_TAP: begin
					if (!tap_go) begin
						if (dom_x_q) begin
							accum_y_q <= '0;
						end else begin
							accum_x_q <= '0;
						end
						state_q <= ST_REPORT;
					end else if (out_free) begin
						n_q  <= n_q + 1'b1;
						nt_q <= nt_q + tmmt_pkg::NT_W'(thr_c);
						if (dom_x_q) begin
							accum_x_q <= pull_v;
						end else begin
							accum_y_q <= pull_v;
						end
					end
				end
				ST_REPORT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers; they need no reset.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					dx_q    <= delta_x;
					dy_q    <= delta_y;
					fresh_q <= fresh_sample;
					mx_q    <= '0;
					my_q    <= '0;
					wh_q    <= '0;
					wv_q    <= '0;
				end
			end
			ST_CMUL: begin
				prod_q <= mul_p;
			end
			ST_CSCL: begin
				if (axis_q) begin
					my_q <= cur_val;
				end else begin
					mx_q <= cur_val;
				end
			end
			ST_SUM: begin
				dom_x_q <= dom_x_c;
				code_q  <= code_c;
				rem_q   <= sum_c;
				quo_q   <= '0;
				neg_q   <= dom_x_c ? accum_x_q[tmmt_pkg::DATA_W-1]
					: accum_y_q[tmmt_pkg::DATA_W-1];
				if (mode_q == tmmt_pkg::MODE_SCROLL && wheel_sat) begin
					if (dom_x_c) begin
						wh_q <= tmmt_pkg::signed_mag(accum_x_q[tmmt_pkg::DATA_W-1],
							tmmt_pkg::MAG_W'(tmmt_pkg::CLAMP_MAX));
					end else begin
						wv_q <= tmmt_pkg::signed_mag(accum_y_q[tmmt_pkg::DATA_W-1],
							tmmt_pkg::MAG_W'(tmmt_pkg::CLAMP_MAX));
					end
				end
			end
			ST_DIV: begin
				rem_q <= rem_n;
				quo_q <= quo_n;
				if (div_cnt_q == '0) begin
					if (dom_x_q) begin
						wh_q <= tmmt_pkg::signed_mag(neg_q, quo_n);
					end else begin
						wv_q <= tmmt_pkg::signed_mag(neg_q, quo_n);
					end
				end
			end
			ST_TAP: begin
				if (tap_go && out_free) begin
					out_kind_q <= tmmt_pkg::KIND_TAP;
					out_code_q <= code_q;
					out_mx_q   <= '0;
					out_my_q   <= '0;
					out_wh_q   <= '0;
					out_wv_q   <= '0;
					out_last_q <= 1'b0;
				end
			end
			ST_REPORT: begin
				if (out_free) begin
					out_kind_q <= tmmt_pkg::KIND_MOUSE;
					out_code_q <= tmmt_pkg::KEY_RIGHT;
					out_mx_q   <= mx_q;
					out_my_q   <= my_q;
					out_wh_q   <= wh_q;
					out_wv_q   <= wv_q;
					out_last_q <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign item_kind = out_kind_q;
	assign key_code  = out_code_q;
	assign move_x    = out_mx_q;
	assign move_y    = out_my_q;
	assign wheel_h   = out_wh_q;
	assign wheel_v   = out_wv_q;
	assign last      = out_last_q;

endmodule

/* src/tmmt_checker.sv */
`timescale 1ns / 1ps

module tmmt_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic                               item_kind,
	input logic [tmmt_pkg::KEY_W-1:0]         key_code,
	input logic signed [tmmt_pkg::MOVE_W-1:0] move_x,
	input logic signed [tmmt_pkg::MOVE_W-1:0] move_y,
	input logic signed [tmmt_pkg::MOVE_W-1:0] wheel_h,
	input logic signed [tmmt_pkg::MOVE_W-1:0] wheel_v,
	input logic                               last
);

	// A beat held back by the sink stays put.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid
			&& $stable({item_kind, key_code, move_x, move_y, wheel_h, wheel_v, last}))
		else $error("output beat changed while stalled");

	// The block works on one input at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");

	// A key tap carries only its code.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && item_kind == tmmt_pkg::KIND_TAP |-> !last && move_x == '0
			&& move_y == '0 && wheel_h == '0 && wheel_v == '0)
		else $error("key tap with mouse fields");

	// A mouse report closes the input and never mixes cursor and wheel motion.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && item_kind == tmmt_pkg::KIND_MOUSE |-> last
			&& key_code == tmmt_pkg::KEY_RIGHT
			&& ((move_x == '0 && move_y == '0) || (wheel_h == '0 && wheel_v == '0)))
		else $error("malformed mouse report");

	// Once idle again, only the closing report can still be waiting.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && out_valid |-> item_kind == tmmt_pkg::KIND_MOUSE)
		else $error("key tap pending while idle");

endmodule

bind trackball_motion_mode_translator tmmt_checker u_tmmt_checker (.*);

/* sim/trackball_motion_mode_translator_tb.sv */
`timescale 1ns / 1ps

// Self-checking bench for the trackball motion translator.
//
// A short table of directed reports runs first. Rows whose outcome is obvious, such as
// a zero report after reset or a saturated cursor move, carry their mouse beat typed
// in. Every other beat comes from a behavioral copy of the translator kept in this
// file. Random phases follow, each with its own register setting. Both handshakes
// idle in random bursts. One long receiver hold backs the block up into its input,
// and the last phase runs with no idling at all.
module trackball_motion_mode_translator_tb;

	import tmmt_pkg::*;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam int TAIL_CYCLES  = 40;
	localparam int NUM_DIRECTED = 25;
	localparam int NUM_PHASES   = 14;
	localparam int HOLD_PHASE   = 3;
	localparam int PAUSE_PHASE  = 7;

	// Mouse beats always carry a zero key code.
	localparam logic [KEY_W-1:0] KEY_NONE = '0;

	// One output beat, laid out the way the result ports present it.
	typedef struct packed {
		logic                     kind;
		logic [KEY_W-1:0]         code;
		logic signed [MOVE_W-1:0] mx;
		logic signed [MOVE_W-1:0] my;
		logic signed [MOVE_W-1:0] wh;
		logic signed [MOVE_W-1:0] wv;
		logic                     last;
	} beat_t;

	// A directed row. When typed is set, the closing mouse beat is the one written here
	// and not the one the model predicts.
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              integ;
		int                dx;
		int                dy;
		logic              fresh;
		logic              typed;
		int                mx;
		int                my;
		int                wh;
		int                wv;
	} stim_row_t;

	// One random phase: a full register setting, the number of reports, the usual
	// delta span, and whether idling is switched off.
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              integ;
		int                gain;
		int                gain_int;
		int                arrow_thr;
		int                arrow_thr_int;
		int                wheel_thr;
		int                wheel_thr_int;
		int                items;
		int                span;
		logic              calm;
	} phase_t;

	typedef struct packed {
		logic  typed;
		beat_t want;
	} report_tag_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic signed [DATA_W-1:0]   delta_x = '0;
	logic signed [DATA_W-1:0]   delta_y = '0;
	logic                       fresh_sample = 1'b0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic                       item_kind;
	logic [KEY_W-1:0]           key_code;
	logic signed [MOVE_W-1:0]   move_x;
	logic signed [MOVE_W-1:0]   move_y;
	logic signed [MOVE_W-1:0]   wheel_h;
	logic signed [MOVE_W-1:0]   wheel_v;
	logic                       last;
	logic                       cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]       cfg_index = '0;
	logic [CFG_DATA_W-1:0]      cfg_wdata = '0;

	// Shadow copy of the register file, starting at the reset values.
	logic [MODE_W-1:0] mode_reg = MODE_CURSOR;
	logic              integ_reg = 1'b0;
	int                gain_reg = 250;
	int                gain_int_reg = 20;
	int                arrow_thr_reg = 24;
	int                arrow_thr_int_reg = 340;
	int                wheel_thr_reg = 1;
	int                wheel_thr_int_reg = 150;

	// Model state: held sensor values and the motion accumulators.
	int held_x = 0;
	int held_y = 0;
	int acc_x = 0;
	int acc_y = 0;

	beat_t       translated_q[$];
	report_tag_t typed_report_q[$];

	int   error_count = 0;
	int   cycle_count = 0;
	logic bursty = 1'b1;
	logic hold_tog = 1'b0;
	logic hold_seen = 1'b0;
	int   hold_left = 0;
	int   stall_left = 0;

	stim_row_t dir_rows [NUM_DIRECTED] = '{
		// Cursor mode with reset gain: zero, both extremes, a small move, and a replay
		// of the held values with fresh_sample low.
		'{MODE_CURSOR, 1'b0,      0,      0, 1'b1, 1'b1,    0,    0, 0,    0},
		'{MODE_CURSOR, 1'b0,  32767, -32768, 1'b1, 1'b1,  127,  127, 0,    0},
		'{MODE_CURSOR, 1'b0, -32768,  32767, 1'b1, 1'b1, -127, -127, 0,    0},
		'{MODE_CURSOR, 1'b0,      1,     -1, 1'b1, 1'b1,    2,    2, 0,    0},
		'{MODE_CURSOR, 1'b0,      5,      5, 1'b0, 1'b1,    2,    2, 0,    0},
		'{MODE_CURSOR, 1'b0,     37,    -80, 1'b1, 1'b0,    0,    0, 0,    0},
		// Integration: the second large report saturates the held values.
		'{MODE_CURSOR, 1'b1,  30000, -30000, 1'b1, 1'b0,    0,    0, 0,    0},
		'{MODE_CURSOR, 1'b1,  30000, -30000, 1'b1, 1'b0,    0,    0, 0,    0},
		'{MODE_CURSOR, 1'b1,   -100,    100, 1'b0, 1'b0,    0,    0, 0,    0},
		// Arrow keys: right, down, then a burst capped at the tap limit and an
		// accumulator driven into saturation.
		'{MODE_ARROW,  1'b0,    100,     10, 1'b1, 1'b0,    0,    0, 0,    0},
		'{MODE_ARROW,  1'b0,     -5,   -200, 1'b1, 1'b0,    0,    0, 0,    0},
		'{MODE_ARROW,  1'b0,  32767,      0, 1'b1, 1'b0,    0,    0, 0,    0},
		'{MODE_ARROW,  1'b0,  32767,      0, 1'b1, 1'b0,    0,    0, 0,    0},
		'{MODE_ARROW,  1'b0,      0,      0, 1'b0, 1'b0,    0,    0, 0,    0},
		'{MODE_ARROW,  1'b0, -32768,  32767, 1'b1, 1'b0,    0,    0, 0,    0},
		// Scroll: saturated vertical step, another vertical step, nothing, then a
		// saturated negative vertical step from the most negative report.
		'{MODE_SCROLL, 1'b0,    300,     20, 1'b1, 1'b0,    0,    0, 0,    0},
		'{MODE_SCROLL, 1'b0,     -3,      7, 1'b1, 1'b0,    0,    0, 0,    0},
		'{MODE_SCROLL, 1'b0,      0,      0, 1'b1, 1'b1,    0,    0, 0,    0},
		'{MODE_SCROLL, 1'b0, -32768, -32768, 1'b1, 1'b1,    0,    0, 0, -127},
		// Volume and brightness: one report toward each key.
		'{MODE_MEDIA,  1'b0,      0,     50, 1'b1, 1'b0,    0,    0, 0,    0},
		'{MODE_MEDIA,  1'b0,      0,    -50, 1'b1, 1'b0,    0,    0, 0,    0},
		'{MODE_MEDIA,  1'b0,     60,      0, 1'b1, 1'b0,    0,    0, 0,    0},
		'{MODE_MEDIA,  1'b0,    -60,      5, 1'b1, 1'b0,    0,    0, 0,    0},
		// Arrow keys with integration and its own threshold.
		'{MODE_ARROW,  1'b1,    200,      0, 1'b1, 1'b0,    0,    0, 0,    0},
		'{MODE_ARROW,  1'b1,    200,      0, 1'b1, 1'b0,    0,    0, 0,    0}
	};

	// The phases walk through every mode, both integration settings, zero gain, zero
	// thresholds and the largest legal register values. The last phase has no idling.
	phase_t phases [NUM_PHASES] = '{
		'{MODE_CURSOR, 1'b0, 1023,   20,  24,  340,   1,  150, 45,   200, 1'b0},
		'{MODE_CURSOR, 1'b1,    1,    1,  24,  340,   1,  150, 35,  3000, 1'b1},
		'{MODE_CURSOR, 1'b0,    0,    0,  24,  340,   1,  150, 15, 32767, 1'b0},
		'{MODE_ARROW,  1'b0,  250,   20,  24,  340,   1,  150, 50,    60, 1'b0},
		'{MODE_ARROW,  1'b0,  250,   20,   1,  340,   1,  150, 25,    10, 1'b0},
		'{MODE_ARROW,  1'b1,  250,   20,  24, 4095,   1,  150, 35,   800, 1'b1},
		'{MODE_ARROW,  1'b1,  250,   20, 255,    0,   1,  150, 20,    50, 1'b0},
		'{MODE_SCROLL, 1'b0,  250,   20,  24,  340,   1,  150, 40,   300, 1'b0},
		'{MODE_SCROLL, 1'b0,  250,   20,  24,  340, 255,  150, 30,   200, 1'b0},
		'{MODE_SCROLL, 1'b1,  250,   20,  24,  340,   1, 4095, 35,   600, 1'b0},
		'{MODE_SCROLL, 1'b1,  250,   20,  24,  340,   0,    0, 20,   100, 1'b1},
		'{MODE_MEDIA,  1'b0,  250,   20,   0,  340,   1,  150, 25,    20, 1'b0},
		'{MODE_MEDIA,  1'b1,  250,   20, 255, 4095,   1,  150, 35,   300, 1'b0},
		'{MODE_ARROW,  1'b0,  250,   20,  40,  340,   1,  150, 60,   100, 1'b1}
	};

	trackball_motion_mode_translator u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.delta_x      (delta_x),
		.delta_y      (delta_y),
		.fresh_sample (fresh_sample),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.item_kind    (item_kind),
		.key_code     (key_code),
		.move_x       (move_x),
		.move_y       (move_y),
		.wheel_h      (wheel_h),
		.wheel_v      (wheel_v),
		.last         (last),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int clamp_to(input int v, input int lim);
		return v > lim ? lim : (v < -lim ? -lim : v);
	endfunction

	function automatic int absval(input int v);
		return v < 0 ? -v : v;
	endfunction

	// Moves an accumulator toward zero by one threshold and stops at zero.
	function automatic int toward_zero(input int v, input int thr);
		if (v > 0) begin
			return v - thr > 0 ? v - thr : 0;
		end
		return v + thr < 0 ? v + thr : 0;
	endfunction

	function automatic beat_t make_beat(input logic kind, input logic [KEY_W-1:0] code,
		input int mx, input int my, input int wh, input int wv, input logic last_flag);
		beat_t b;
		b.kind = kind;
		b.code = code;
		b.mx   = MOVE_W'(mx);
		b.my   = MOVE_W'(my);
		b.wh   = MOVE_W'(wh);
		b.wv   = MOVE_W'(wv);
		b.last = last_flag;
		return b;
	endfunction

	function automatic string beat_text(input beat_t b);
		return $sformatf("kind=%0d key=%0d mx=%0d my=%0d wh=%0d wv=%0d last=%0d",
			b.kind, b.code, b.mx, b.my, b.wh, b.wv, b.last);
	endfunction

	// Translates one accepted report into the beats it must produce and queues them in
	// order: any key taps first, then the closing mouse beat.
	task automatic translate_motion(input int dx, input int dy, input logic fresh);
		int mx;
		int my;
		int wh;
		int wv;
		int gain;
		int thr;
		int total;
		int taps;
		logic on_x;
		logic media;
		logic [KEY_W-1:0] key;
		mx = 0;
		my = 0;
		wh = 0;
		wv = 0;
		if (fresh) begin
			if (integ_reg) begin
				held_x = clamp_to(held_x + dx, SAT_LIM);
				held_y = clamp_to(held_y + dy, SAT_LIM);
			end else begin
				held_x = dx;
				held_y = dy;
			end
		end
		if (mode_reg == MODE_CURSOR) begin
			// The products fit easily in 32 bits, and division truncates toward zero.
			gain = integ_reg ? gain_int_reg : gain_reg;
			mx = clamp_to(held_x * gain / PERCENT, CLAMP_MAX);
			my = clamp_to(-held_y * gain / PERCENT, CLAMP_MAX);
		end else begin
			acc_x = clamp_to(acc_x + held_x, SAT_LIM);
			acc_y = clamp_to(acc_y + held_y, SAT_LIM);
			total = absval(acc_x) + absval(acc_y);
			if (mode_reg == MODE_SCROLL) begin
				thr = integ_reg ? wheel_thr_int_reg : wheel_thr_reg;
				if (thr == 0) begin
					thr = 1;
				end
				if (total >= thr) begin
					// A tie between the axes goes to the vertical wheel.
					if (absval(acc_x) > absval(acc_y)) begin
						wh = clamp_to((acc_x > 0 ? total : -total) / thr, CLAMP_MAX);
					end else if (acc_y != 0) begin
						wv = clamp_to((acc_y > 0 ? total : -total) / thr, CLAMP_MAX);
					end
					acc_x = 0;
					acc_y = 0;
				end
			end else begin
				// Volume and brightness ignore the integration threshold.
				media = (mode_reg == MODE_MEDIA);
				thr = (!media && integ_reg) ? arrow_thr_int_reg : arrow_thr_reg;
				if (thr == 0) begin
					thr = 1;
				end
				if (total >= thr) begin
					on_x = absval(acc_x) > absval(acc_y);
					if (on_x) begin
						key = media ? (acc_x > 0 ? KEY_BRIGHT_UP : KEY_BRIGHT_DOWN)
							: (acc_x > 0 ? KEY_RIGHT : KEY_LEFT);
					end else begin
						key = media ? (acc_y > 0 ? KEY_VOL_UP : KEY_VOL_DOWN)
							: (acc_y > 0 ? KEY_UP : KEY_DOWN);
					end
					// The tap count bound is recomputed after every tap.
					taps = 0;
					while (taps < MAX_TAPS && taps <= (absval(acc_x) + absval(acc_y)) / thr) begin
						translated_q.push_back(make_beat(KIND_TAP, key, 0, 0, 0, 0, 1'b0));
						taps++;
						if (on_x) begin
							acc_x = toward_zero(acc_x, thr);
						end else begin
							acc_y = toward_zero(acc_y, thr);
						end
					end
					if (on_x) begin
						acc_y = 0;
					end else begin
						acc_x = 0;
					end
				end
			end
		end
		translated_q.push_back(make_beat(KIND_MOUSE, KEY_NONE, mx, my, wh, wv, 1'b1));
	endtask

	task automatic flag_error(input string msg);
		if (error_count < 10) begin
			$display("ERROR at cycle %0d: %s", cycle_count, msg);
		end
		error_count++;
	endtask

	// Drives one register write at the next edge and mirrors it into the shadow copy. The
	// caller lowers the write enable once its sequence of writes is done.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= CFG_DATA_W'(value);
		case (idx)
			REG_MODE:          mode_reg = MODE_W'(value);
			REG_INTEGRATE:     integ_reg = value[0];
			REG_GAIN:          gain_reg = value & 'h3FF;
			REG_GAIN_INT:      gain_int_reg = value & 'h3FF;
			REG_ARROW_THR:     arrow_thr_reg = value & 'hFF;
			REG_ARROW_THR_INT: arrow_thr_int_reg = value & 'hFFF;
			REG_WHEEL_THR:     wheel_thr_reg = value & 'hFF;
			REG_WHEEL_THR_INT: wheel_thr_int_reg = value & 'hFFF;
			default: ;
		endcase
	endtask

	// Offers one report and returns at the edge where it is accepted. A random gap may
	// come first when idling is on. The tag tells the checker whether the closing
	// mouse beat of this report is typed in.
	task automatic send_report(input int dx, input int dy, input logic fresh,
		input logic typed, input beat_t want);
		report_tag_t tag;
		if (bursty && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		tag.typed = typed;
		tag.want  = want;
		typed_report_q.push_back(tag);
		in_valid     <= 1'b1;
		delta_x      <= DATA_W'(dx);
		delta_y      <= DATA_W'(dy);
		fresh_sample <= fresh;
		do @(posedge clk); while (!in_ready);
	endtask

	// Stops offering reports and waits until every predicted beat has come out. The
	// first edge makes sure that a report accepted just now has already been translated.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (translated_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Mostly small deltas around the phase span, with some zeros and some fully random
	// 16-bit patterns so that every input bit toggles.
	function automatic int pick_delta(input int span);
		logic signed [DATA_W-1:0] raw;
		raw = DATA_W'($urandom);
		case ($urandom_range(0, 11))
			0: return raw;
			1: return 0;
			default: return int'($urandom_range(0, 2 * span)) - span;
		endcase
	endfunction

	// The receiver. A toggle of hold_tog starts one long hold that this process counts
	// down by itself. Otherwise it stalls in random bursts while idling is on.
	always @(posedge clk) begin
		if (hold_tog != hold_seen) begin
			hold_seen <= hold_tog;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready  <= 1'b0;
		end else if (bursty && $urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(0, 12);
			out_ready  <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// The checker. An accepted input beat is translated before any output beat of the
	// same edge is checked. Each output beat is compared with the oldest prediction.
	always @(posedge clk) begin : check_beats
		report_tag_t tag;
		beat_t got;
		beat_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				tag = '0;
				if (typed_report_q.size() != 0) begin
					tag = typed_report_q.pop_front();
				end
				translate_motion(delta_x, delta_y, fresh_sample);
				if (tag.typed) begin
					translated_q[translated_q.size() - 1] = tag.want;
				end
			end
			if (out_valid && out_ready) begin
				got = make_beat(item_kind, key_code, move_x, move_y, wheel_h, wheel_v, last);
				if (translated_q.size() == 0) begin
					flag_error($sformatf("beat with nothing predicted: %s", beat_text(got)));
				end else begin
					want = translated_q.pop_front();
					if (got.kind !== want.kind || got.code !== want.code
						|| got.mx !== want.mx || got.my !== want.my
						|| got.wh !== want.wh || got.wv !== want.wv
						|| got.last !== want.last) begin
						flag_error($sformatf("expected %s, got %s",
							beat_text(want), beat_text(got)));
					end
				end
			end
		end
	end

	// The limit is several times the slowest correct run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin : stimulus
		beat_t want;
		int p;
		int k;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows. The mode and integration registers change only between groups,
		// and only after the block has gone quiet.
		foreach (dir_rows[i]) begin
			if (dir_rows[i].mode != mode_reg || dir_rows[i].integ != integ_reg) begin
				wait_drained();
				write_reg(REG_MODE, dir_rows[i].mode);
				write_reg(REG_INTEGRATE, dir_rows[i].integ);
				@(posedge clk);
				cfg_we <= 1'b0;
			end
			want = make_beat(KIND_MOUSE, KEY_NONE, dir_rows[i].mx, dir_rows[i].my,
				dir_rows[i].wh, dir_rows[i].wv, 1'b1);
			send_report(dir_rows[i].dx, dir_rows[i].dy, dir_rows[i].fresh,
				dir_rows[i].typed, want);
		end

		// Random phases. Every register is rewritten at the start of each phase.
		for (p = 0; p < NUM_PHASES; p++) begin
			wait_drained();
			write_reg(REG_MODE, phases[p].mode);
			write_reg(REG_INTEGRATE, phases[p].integ);
			write_reg(REG_GAIN, phases[p].gain);
			write_reg(REG_GAIN_INT, phases[p].gain_int);
			write_reg(REG_ARROW_THR, phases[p].arrow_thr);
			write_reg(REG_ARROW_THR_INT, phases[p].arrow_thr_int);
			write_reg(REG_WHEEL_THR, phases[p].wheel_thr);
			write_reg(REG_WHEEL_THR_INT, phases[p].wheel_thr_int);
			@(posedge clk);
			cfg_we <= 1'b0;
			bursty <= !phases[p].calm;
			// In the first key phase the receiver holds off for a long stretch while
			// reports keep coming, so the block backs up into its input.
			if (p == HOLD_PHASE) begin
				hold_tog <= !hold_tog;
			end
			for (k = 0; k < phases[p].items; k++) begin
				// Partway through one scroll phase the sender waits for every beat.
				if (p == PAUSE_PHASE && k == phases[p].items / 2) begin
					wait_drained();
				end
				send_report(pick_delta(phases[p].span), pick_delta(phases[p].span),
					$urandom_range(0, 7) != 0, 1'b0, '0);
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0 && translated_q.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

/* sim.f */
src/tmmt_pkg.sv
src/trackball_motion_mode_translator.sv
src/tmmt_checker.sv
sim/trackball_motion_mode_translator_tb.sv
